// ===== rtl/kcht_pkg.sv =====
// kcht_pkg: shared types and codes for the keyed counter hash table
// no dependencies
package kcht_pkg;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_SELL   = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam int KEY_W   = 15;
    localparam int PRICE_W = 16;
    localparam int COUNT_W = 16;
    localparam int REV_W   = 32;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
    } t_req;
endpackage

// ===== rtl/kcht_front.sv =====
// kcht_front: two-entry input request queue
// depends on kcht_pkg
module kcht_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kcht_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output kcht_pkg::t_req o_req
);
    import kcht_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== rtl/kcht_back.sv =====
// kcht_back: probe sequencer over the slot memories, clearing pass, result register
// depends on kcht_pkg
module kcht_back #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  kcht_pkg::t_req                i_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [kcht_pkg::COUNT_W-1:0]  o_item_count,
    output logic [kcht_pkg::REV_W-1:0]    o_revenue_total
);
    import kcht_pkg::*;

    localparam int AW = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PW = $clog2(TABLE_SLOTS + 1);
    localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_HASH = 3'd2,
                           S_READ = 3'd3, S_CHECK = 3'd4, S_OUT = 3'd5;

    // valid + count in one memory, key + price in another
    logic [COUNT_W:0]         r_vc [TABLE_SLOTS];
    logic [KEY_W+PRICE_W-1:0] r_kp [TABLE_SLOTS];

    logic [2:0]         r_state;
    t_req               r_req;
    logic [AW-1:0]      r_pos, r_home, r_clr;
    logic [PW-1:0]      r_n;
    logic [2*KEY_W:0]   r_sq;
    logic [COUNT_W:0]   r_vc_rd;
    logic [KEY_W+PRICE_W-1:0] r_kp_rd;
    logic [REV_W-1:0]   r_rev;
    logic               r_ov;
    logic [1:0]         r_st;
    logic [COUNT_W-1:0] r_cnt;

    logic               w_hit, w_we, w_go, w_done, w_fin, w_kp_we;
    logic [COUNT_W:0]   w_vc_wr;
    logic [AW+KEY_W:0]  w_next;
    logic [REV_W:0]     w_sum;

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ov;
    assign o_status        = r_st;
    assign o_item_count    = r_cnt;
    assign o_revenue_total = r_rev;

    assign w_hit  = !r_vc_rd[COUNT_W] || (r_kp_rd[KEY_W+PRICE_W-1:PRICE_W] == r_req.key);
    assign w_go   = !r_ov || i_ready;
    assign w_done = (r_state == S_CHECK) && (w_hit || r_n == PW'(TABLE_SLOTS - 1));
    assign w_fin  = w_done && w_go;
    assign w_kp_we = (r_state == S_CHECK) && w_hit && w_go && r_req.cmd == CMD_INSERT
                     && !r_vc_rd[COUNT_W];
    assign w_next = ({{(KEY_W+1){1'b0}}, r_home} + {{(AW+1){1'b0}}, r_req.key}
                    + {{(KEY_W+1){1'b0}}, r_n[AW-1:0]} + (AW+KEY_W+1)'(1))
                    % (AW+KEY_W+1)'(TABLE_SLOTS);
    assign w_sum  = {1'b0, r_rev} + {{(REV_W-PRICE_W+1){1'b0}}, r_kp_rd[PRICE_W-1:0]};

    always_comb begin
        w_we    = 1'b0;
        w_vc_wr = r_vc_rd;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_vc_wr = '0;
        end else if (r_state == S_CHECK && w_hit && w_go) begin
            if (r_req.cmd == CMD_INSERT) begin
                w_we = 1'b1;
                if (!r_vc_rd[COUNT_W]) w_vc_wr = {1'b1, COUNT_W'(1)};
                else if (r_vc_rd[COUNT_W-1:0] != '1)
                    w_vc_wr = {1'b1, r_vc_rd[COUNT_W-1:0] + COUNT_W'(1)};
            end else if (r_req.cmd == CMD_SELL && r_vc_rd[COUNT_W]
                         && r_vc_rd[COUNT_W-1:0] != '0) begin
                w_we    = 1'b1;
                w_vc_wr = {1'b1, r_vc_rd[COUNT_W-1:0] - COUNT_W'(1)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_vc[(r_state == S_CLEAR) ? r_clr : r_pos] <= w_vc_wr;
        end
        if (w_kp_we) begin
            r_kp[r_pos] <= {r_req.key, r_req.price};
        end
        r_vc_rd <= r_vc[r_pos];
        r_kp_rd <= r_kp[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_rev   <= '0;
        end else begin
            if (w_fin) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(TABLE_SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_req;
                        r_sq    <= {1'b0, {{KEY_W{1'b0}}, i_req.key}
                                          * {{KEY_W{1'b0}}, i_req.key}};
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    r_home  <= AW'((r_sq + (2*KEY_W+1)'(1)) % (2*KEY_W+1)'(TABLE_SLOTS));
                    r_pos   <= AW'((r_sq + (2*KEY_W+1)'(1)) % (2*KEY_W+1)'(TABLE_SLOTS));
                    r_n     <= '0;
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (w_done) begin
                        if (w_go) begin
                            r_state <= S_IDLE;
                            if (!w_hit) begin
                                r_st <= ST_FULL; r_cnt <= '0;
                            end else if (r_req.cmd == CMD_INSERT) begin
                                r_st <= ST_OK; r_cnt <= w_vc_wr[COUNT_W-1:0];
                            end else if (r_req.cmd == CMD_SELL) begin
                                if (r_vc_rd[COUNT_W] && r_vc_rd[COUNT_W-1:0] != '0) begin
                                    r_st  <= ST_OK;
                                    r_cnt <= w_vc_wr[COUNT_W-1:0];
                                    r_rev <= w_sum[REV_W] ? '1 : w_sum[REV_W-1:0];
                                end else begin
                                    r_st <= ST_NOTFOUND; r_cnt <= '0;
                                end
                            end else if (r_vc_rd[COUNT_W]) begin
                                r_st <= ST_OK; r_cnt <= r_vc_rd[COUNT_W-1:0];
                            end else begin
                                r_st <= ST_NOTFOUND; r_cnt <= '0;
                            end
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_pos   <= AW'(w_next);
                        r_n     <= r_n + PW'(1);
                        r_state <= S_READ;
                    end
                end
                S_OUT: r_state <= S_READ;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/keyed_count_hash_table.sv =====
// keyed_count_hash_table: top level, request queue feeding the probe sequencer
// depends on kcht_pkg, kcht_front, kcht_back
//
// channel  | handshake          | beat
// request  | i_valid / o_ready  | i_command, i_item_key, i_item_price
// result   | o_valid / i_ready  | o_status, o_item_count, o_revenue_total
//
// each item passes through the hash state, then a read state and a check state per probe (one memory read per probe)
// after reset a clearing pass clears the valid/count of every slot before items are taken
// a result held by the receiver makes the sequencer retry the last probe through the out, read and check states
// the queue keeps accepting up to two items while the sequencer or result is stalled
module keyed_count_hash_table #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [14:0] i_item_key,
    input  logic [15:0] i_item_price,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_item_count,
    output logic [31:0] o_revenue_total
);
    import kcht_pkg::*;

    t_req w_in, w_q;
    logic w_qv, w_qr;

    assign w_in = '{cmd: i_command, key: i_item_key, price: i_item_price};

    kcht_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_req(w_q)
    );

    kcht_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_req(w_q),
        .o_valid, .i_ready, .o_status, .o_item_count, .o_revenue_total
    );
endmodule
